>>> src/mfdu_pkg.sv
// mfdu_pkg: shared types, constants and register indexes for the motor feedback
// dispatch and trigger angle unwrap block. No dependencies.
package mfdu_pkg;

    localparam int ID_W       = 11;
    localparam int WORD_W     = 16;
    localparam int TEMP_W     = 8;
    localparam int SLOT_W     = 4;
    localparam int NUM_SLOTS  = 14;
    localparam int CFG_N      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int ROUNDS_W   = 6;
    localparam int ANGLE_W    = 19;
    localparam int SUM_W      = 20;
    localparam int CALIB_W    = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_FRIC_ONE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRIC_TWO     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_ONE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_TWO    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CHASSIS_BASE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_BASE   = 3'd7;

    localparam logic [SLOT_W-1:0] TRIG_SLOT    = 4'd2;
    localparam logic [SLOT_W-1:0] CHASSIS_SLOT = 4'd6;
    localparam logic [SLOT_W-1:0] STEER_SLOT   = 4'd10;

    localparam logic [CALIB_W-1:0] CALIBRATION_FRAMES = 6'd50;

    localparam logic signed [WORD_W:0]    HALF_TURN   = 17'sd4096;
    localparam logic signed [ROUNDS_W-1:0] ROUNDS_UNDER = -6'sd18;
    localparam logic signed [ROUNDS_W-1:0] ROUNDS_TOP   = 6'sd18;
    localparam logic signed [ROUNDS_W-1:0] ROUNDS_OVER  = 6'sd19;
    localparam logic signed [ROUNDS_W-1:0] ROUNDS_LOW   = -6'sd17;
    localparam logic signed [SUM_W-1:0]   ANGLE_MAX   = 20'sd147455;
    localparam logic signed [SUM_W-1:0]   ANGLE_MIN   = -20'sd147456;
    localparam logic signed [SUM_W-1:0]   ANGLE_SPAN  = 20'sd294912;

    typedef logic [ID_W-1:0] t_id;
    typedef t_id [CFG_N-1:0] t_cfg;

    localparam t_cfg CFG_RESET = {11'd517, 11'd513, 11'd519, 11'd518,
                                  11'd517, 11'd515, 11'd514, 11'd513};

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } t_match;

    typedef struct packed {
        logic [WORD_W-1:0]          enc;
        logic [WORD_W-1:0]          prev;
        logic [WORD_W-1:0]          zero;
        logic signed [ROUNDS_W-1:0] rounds;
    } t_trig_in;

    typedef struct packed {
        logic signed [ROUNDS_W-1:0] rounds;
        logic signed [ANGLE_W-1:0]  total;
    } t_trig_out;

endpackage

>>> src/mfdu_in_if.sv
// mfdu_in_if: valid/ready channel carrying one received feedback frame.
// Depends on mfdu_pkg for field widths.
interface mfdu_in_if;
    logic                            valid;
    logic                            ready;
    logic                            bus;
    logic [mfdu_pkg::ID_W-1:0]       frame_id;
    logic [mfdu_pkg::WORD_W-1:0]     angle_word;
    logic [mfdu_pkg::WORD_W-1:0]     speed_word;
    logic [mfdu_pkg::WORD_W-1:0]     current_word;
    logic [mfdu_pkg::TEMP_W-1:0]     temperature;

    modport source (output valid, bus, frame_id, angle_word, speed_word, current_word,
                    temperature, input ready);
    modport sink (input valid, bus, frame_id, angle_word, speed_word, current_word,
                  temperature, output ready);
endinterface

>>> src/mfdu_out_if.sv
// mfdu_out_if: valid/ready channel carrying one updated motor slot record.
// Depends on mfdu_pkg for field widths.
interface mfdu_out_if;
    logic                                   valid;
    logic                                   ready;
    logic [mfdu_pkg::SLOT_W-1:0]            slot;
    logic [mfdu_pkg::WORD_W-1:0]            encoder;
    logic [mfdu_pkg::WORD_W-1:0]            previous_encoder;
    logic [mfdu_pkg::WORD_W-1:0]            speed;
    logic [mfdu_pkg::WORD_W-1:0]            current;
    logic [mfdu_pkg::TEMP_W-1:0]            temp_out;
    logic signed [mfdu_pkg::ANGLE_W-1:0]    unwound_angle;
    logic signed [mfdu_pkg::ROUNDS_W-1:0]   turn_count;
    logic                                   calibrating;

    modport source (output valid, slot, encoder, previous_encoder, speed, current,
                    temp_out, unwound_angle, turn_count, calibrating, input ready);
    modport sink (input valid, slot, encoder, previous_encoder, speed, current,
                  temp_out, unwound_angle, turn_count, calibrating, output ready);
endinterface

>>> src/motor_feedback_dispatch_unwrap_unit.sv
// Motor feedback dispatch with trigger multi-turn unwrap; top level.
// Depends on mfdu_pkg, mfdu_in_if, mfdu_out_if, mfdu_slot_match, mfdu_unwrap.
//
// Accepts one feedback frame per clock while not stalled. A frame is captured in an
// input register; from there it is matched to a slot, the slot record and trigger state
// are read, updated and written back, and the record is loaded into the result
// register when that register is empty or being taken, one transaction per cycle
// sustained while results are taken. Unmatched frames produce no result. The result
// register frees the input side while a record waits to be taken; both stall only
// when the result is held and the input register is full. Register writes are taken
// at any edge with i_cfg_we high and should be made while the block is idle.
module motor_feedback_dispatch_unwrap_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mfdu_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mfdu_pkg::ID_W-1:0]      i_cfg_data,
    mfdu_in_if.sink                        i_in,
    mfdu_out_if.source                     o_out
);

    mfdu_pkg::t_cfg r_cfg;

    logic                          r_in_vld;
    logic                          r_bus;
    logic [mfdu_pkg::ID_W-1:0]     r_frame_id;
    logic [mfdu_pkg::WORD_W-1:0]   r_angle;
    logic [mfdu_pkg::WORD_W-1:0]   r_speed;
    logic [mfdu_pkg::WORD_W-1:0]   r_current;
    logic [mfdu_pkg::TEMP_W-1:0]   r_temp;

    logic [mfdu_pkg::WORD_W-1:0]   r_enc      [mfdu_pkg::NUM_SLOTS];
    logic [mfdu_pkg::WORD_W-1:0]   r_prev     [mfdu_pkg::NUM_SLOTS];
    logic [mfdu_pkg::WORD_W-1:0]   r_spd      [mfdu_pkg::NUM_SLOTS];
    logic [mfdu_pkg::WORD_W-1:0]   r_cur      [mfdu_pkg::NUM_SLOTS];
    logic [mfdu_pkg::TEMP_W-1:0]   r_tmp      [mfdu_pkg::NUM_SLOTS];

    logic [mfdu_pkg::WORD_W-1:0]          r_zero;
    logic signed [mfdu_pkg::ROUNDS_W-1:0] r_rounds;
    logic [mfdu_pkg::CALIB_W-1:0]         r_calib;

    logic                                 r_out_vld;
    logic [mfdu_pkg::SLOT_W-1:0]          r_o_slot;
    logic [mfdu_pkg::WORD_W-1:0]          r_o_enc;
    logic [mfdu_pkg::WORD_W-1:0]          r_o_prev;
    logic [mfdu_pkg::WORD_W-1:0]          r_o_spd;
    logic [mfdu_pkg::WORD_W-1:0]          r_o_cur;
    logic [mfdu_pkg::TEMP_W-1:0]          r_o_tmp;
    logic signed [mfdu_pkg::ANGLE_W-1:0]  r_o_total;
    logic signed [mfdu_pkg::ROUNDS_W-1:0] r_o_turns;
    logic                                 r_o_cal;

    mfdu_pkg::t_match    match;
    mfdu_pkg::t_trig_in  trig_in;
    mfdu_pkg::t_trig_out trig_out;

    logic                        advance;
    logic                        take;
    logic                        is_trig;
    logic                        capture;
    logic [mfdu_pkg::WORD_W-1:0] n_prev;
    logic [mfdu_pkg::WORD_W-1:0] n_spd;
    logic [mfdu_pkg::WORD_W-1:0] n_cur;
    logic [mfdu_pkg::TEMP_W-1:0] n_tmp;
    logic [mfdu_pkg::WORD_W-1:0] n_zero;

    assign advance    = r_in_vld && (!r_out_vld || o_out.ready);
    assign take       = advance && match.hit;
    assign i_in.ready = !r_in_vld || advance;

    mfdu_slot_match u_match (
        .i_bus      (r_bus),
        .i_frame_id (r_frame_id),
        .i_cfg      (r_cfg),
        .o_match    (match)
    );

    assign is_trig = match.hit && (match.slot == mfdu_pkg::TRIG_SLOT);
    assign capture = is_trig && (r_calib < mfdu_pkg::CALIBRATION_FRAMES);

    // capture frames refresh the encoder, zero offset and turn count, and keep the other fields
    assign n_prev = capture ? r_prev[match.slot] : r_enc[match.slot];
    assign n_spd  = capture ? r_spd[match.slot]  : r_speed;
    assign n_cur  = capture ? r_cur[match.slot]  : r_current;
    assign n_tmp  = capture ? r_tmp[match.slot]  : r_temp;
    assign n_zero = capture ? r_angle : r_zero;

    assign trig_in.enc    = r_angle;
    assign trig_in.prev   = n_prev;
    assign trig_in.zero   = n_zero;
    assign trig_in.rounds = r_rounds;

    mfdu_unwrap u_unwrap (
        .i_trig (trig_in),
        .o_trig (trig_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= mfdu_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_bus      <= i_in.bus;
            r_frame_id <= i_in.frame_id;
            r_angle    <= i_in.angle_word;
            r_speed    <= i_in.speed_word;
            r_current  <= i_in.current_word;
            r_temp     <= i_in.temperature;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < mfdu_pkg::NUM_SLOTS; k++) begin
                r_enc[k]  <= '0;
                r_prev[k] <= '0;
                r_spd[k]  <= '0;
                r_cur[k]  <= '0;
                r_tmp[k]  <= '0;
            end
            r_zero   <= '0;
            r_rounds <= '0;
            r_calib  <= '0;
        end else if (take) begin
            r_enc[match.slot]  <= r_angle;
            r_prev[match.slot] <= n_prev;
            r_spd[match.slot]  <= n_spd;
            r_cur[match.slot]  <= n_cur;
            r_tmp[match.slot]  <= n_tmp;
            if (is_trig) begin
                r_zero   <= n_zero;
                r_rounds <= trig_out.rounds;
                if (capture) begin
                    r_calib <= r_calib + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= match.hit;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_o_slot  <= match.slot;
            r_o_enc   <= r_angle;
            r_o_prev  <= n_prev;
            r_o_spd   <= n_spd;
            r_o_cur   <= n_cur;
            r_o_tmp   <= n_tmp;
            r_o_total <= is_trig ? trig_out.total : '0;
            r_o_turns <= is_trig ? trig_out.rounds : '0;
            r_o_cal   <= capture;
        end
    end

    assign o_out.valid            = r_out_vld;
    assign o_out.slot             = r_o_slot;
    assign o_out.encoder          = r_o_enc;
    assign o_out.previous_encoder = r_o_prev;
    assign o_out.speed            = r_o_spd;
    assign o_out.current          = r_o_cur;
    assign o_out.temp_out         = r_o_tmp;
    assign o_out.unwound_angle    = r_o_total;
    assign o_out.turn_count       = r_o_turns;
    assign o_out.calibrating      = r_o_cal;

endmodule

>>> src/mfdu_slot_match.sv
// mfdu_slot_match: maps bus and frame identifier to a motor slot, first match wins.
// Depends on mfdu_pkg.
module mfdu_slot_match (
    input  logic                      i_bus,
    input  logic [mfdu_pkg::ID_W-1:0] i_frame_id,
    input  mfdu_pkg::t_cfg            i_cfg,
    output mfdu_pkg::t_match          o_match
);

    logic [mfdu_pkg::ID_W:0] chassis_diff;
    logic [mfdu_pkg::ID_W:0] steer_diff;
    logic                    chassis_hit;
    logic                    steer_hit;
    mfdu_pkg::t_match        bus0_match;

    assign chassis_diff = {1'b0, i_frame_id} - {1'b0, i_cfg[mfdu_pkg::CFG_CHASSIS_BASE]};
    assign steer_diff   = {1'b0, i_frame_id} - {1'b0, i_cfg[mfdu_pkg::CFG_STEER_BASE]};
    assign chassis_hit  = (chassis_diff[mfdu_pkg::ID_W:2] == '0);
    assign steer_hit    = (steer_diff[mfdu_pkg::ID_W:2] == '0);

    always_comb begin
        bus0_match = '0;
        // scan downwards so the lowest matching slot wins
        for (int k = 5; k >= 0; k--) begin
            if (i_cfg[k] == i_frame_id) begin
                bus0_match.hit  = 1'b1;
                bus0_match.slot = mfdu_pkg::SLOT_W'(k);
            end
        end
    end

    always_comb begin
        o_match = '0;
        if (!i_bus) begin
            o_match = bus0_match;
        end else if (chassis_hit) begin
            o_match.hit  = 1'b1;
            o_match.slot = mfdu_pkg::CHASSIS_SLOT + {2'b00, chassis_diff[1:0]};
        end else if (steer_hit) begin
            o_match.hit  = 1'b1;
            o_match.slot = mfdu_pkg::STEER_SLOT + {2'b00, steer_diff[1:0]};
        end
    end

endmodule

>>> src/mfdu_unwrap.sv
// mfdu_unwrap: trigger motor multi-turn unwrap, turn count wrap and angle fold.
// Depends on mfdu_pkg.
module mfdu_unwrap (
    input  mfdu_pkg::t_trig_in  i_trig,
    output mfdu_pkg::t_trig_out o_trig
);

    logic signed [mfdu_pkg::WORD_W:0]     delta;
    logic signed [mfdu_pkg::ROUNDS_W-1:0] rounds_step;
    logic signed [mfdu_pkg::ROUNDS_W-1:0] rounds_wrap;
    logic signed [mfdu_pkg::SUM_W-1:0]    sum;

    assign delta = $signed({1'b0, i_trig.enc}) - $signed({1'b0, i_trig.prev});

    always_comb begin
        rounds_step = i_trig.rounds;
        if (delta > mfdu_pkg::HALF_TURN) begin
            rounds_step = i_trig.rounds - 6'sd1;
        end else if (delta < -mfdu_pkg::HALF_TURN) begin
            rounds_step = i_trig.rounds + 6'sd1;
        end
        rounds_wrap = rounds_step;
        if (rounds_step == mfdu_pkg::ROUNDS_UNDER) begin
            rounds_wrap = mfdu_pkg::ROUNDS_TOP;
        end else if (rounds_step == mfdu_pkg::ROUNDS_OVER) begin
            rounds_wrap = mfdu_pkg::ROUNDS_LOW;
        end
    end

    assign sum = $signed({rounds_wrap[mfdu_pkg::ROUNDS_W-1], rounds_wrap, 13'd0})
               + $signed({4'd0, i_trig.enc}) - $signed({4'd0, i_trig.zero});

    always_comb begin
        o_trig.rounds = rounds_wrap;
        if (sum > mfdu_pkg::ANGLE_MAX) begin
            o_trig.total = mfdu_pkg::ANGLE_W'(sum - mfdu_pkg::ANGLE_SPAN);
        end else if (sum < mfdu_pkg::ANGLE_MIN) begin
            o_trig.total = mfdu_pkg::ANGLE_W'(sum + mfdu_pkg::ANGLE_SPAN);
        end else begin
            o_trig.total = mfdu_pkg::ANGLE_W'(sum);
        end
    end

endmodule

>>> src/mfdu_checker.sv
// mfdu_checker: port-level assertions on the result channel, bound to the top level.
// Depends on mfdu_pkg and motor_feedback_dispatch_unwrap_unit.
module mfdu_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_out_valid,
    input logic                                 i_out_ready,
    input logic [mfdu_pkg::SLOT_W-1:0]          i_slot,
    input logic signed [mfdu_pkg::ANGLE_W-1:0]  i_total,
    input logic signed [mfdu_pkg::ROUNDS_W-1:0] i_turns,
    input logic                                 i_cal
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_slot) && $stable(i_total))
        else $error("result transaction changed while stalled");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_slot < 4'd14)
        else $error("slot out of range");

    a_non_trig_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_slot != mfdu_pkg::TRIG_SLOT) |->
            (i_total == '0) && (i_turns == '0) && !i_cal)
        else $error("trigger fields set on another slot");

    a_turn_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_turns >= mfdu_pkg::ROUNDS_LOW) && (i_turns <= mfdu_pkg::ROUNDS_TOP))
        else $error("turn count outside wrap range");

    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_out_valid)
        else $error("result valid straight after reset");

endmodule

bind motor_feedback_dispatch_unwrap_unit mfdu_checker u_mfdu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_slot      (o_out.slot),
    .i_total     (o_out.unwound_angle),
    .i_turns     (o_out.turn_count),
    .i_cal       (o_out.calibrating)
);
